// ===== hdl/utl1_pkg.sv =====
// ----------------------------------------------------------------------------
// utl1_pkg
// Shared types, constants and lead-byte decode helpers for the UTF-8 to
// Latin-1 decoder.
// ----------------------------------------------------------------------------
package utl1_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ACCUM_W = 32;
    localparam int unsigned COUNT_W = 3;

    localparam logic [BYTE_W-1:0] ASCII_LIMIT  = 8'h80;
    localparam logic [BYTE_W-1:0] CONT_OFFSET  = 8'h80;
    localparam logic [BYTE_W-1:0] SUBST_CHAR   = 8'h3F;
    localparam logic [BYTE_W-1:0] FULL_MASK    = 8'hFF;
    localparam logic [BYTE_W-1:0] LATIN1_MAX   = 8'hFF;
    localparam logic [BYTE_W-1:0] END_OF_TEXT  = 8'h00;

    localparam logic [COUNT_W-1:0] LEN_ONE   = 3'd1;
    localparam logic [COUNT_W-1:0] LEN_TWO   = 3'd2;
    localparam logic [COUNT_W-1:0] LEN_THREE = 3'd3;
    localparam logic [COUNT_W-1:0] LEN_FOUR  = 3'd4;
    localparam logic [COUNT_W-1:0] LEN_FIVE  = 3'd5;
    localparam logic [COUNT_W-1:0] LEN_SIX   = 3'd6;

    // One byte moving between stages
    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } beat_t;

    // Sequence length from the lead byte's bit tests
    function automatic logic [COUNT_W-1:0] seq_len(input logic [BYTE_W-1:0] b);
        logic [COUNT_W-1:0] len;
        begin
            if (b < ASCII_LIMIT)
                len = LEN_ONE;
            else if (b[5] == 1'b0)
                len = LEN_TWO;
            else if (b[4] == 1'b0)
                len = LEN_THREE;
            else if (b[3] == 1'b0)
                len = LEN_FOUR;
            else if (b[2] == 1'b0)
                len = LEN_FIVE;
            else
                len = LEN_SIX;
            return len;
        end
    endfunction

    // Bit position of 6-bit group k (k * 6), k in 0..5
    function automatic logic [4:0] group_pos(input logic [COUNT_W-1:0] k);
        logic [4:0] pos;
        begin
            unique case (k)
                3'd0:    pos = 5'd0;
                3'd1:    pos = 5'd6;
                3'd2:    pos = 5'd12;
                3'd3:    pos = 5'd18;
                3'd4:    pos = 5'd24;
                3'd5:    pos = 5'd30;
                default: pos = 5'd0;
            endcase
            return pos;
        end
    endfunction

endpackage

// ===== hdl/utf8_to_latin1_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_to_latin1_decoder
// Byte-serial UTF-8 to Latin-1 converter with valid/ready channels.
// ----------------------------------------------------------------------------
// Feed one UTF-8 byte per beat on in_byte; each completed sequence yields one
// Latin-1 beat on latin1_char. Lead bytes set a sequence length of 1 to 6
// (legacy 5- and 6-byte forms included, bytes 0x80..0xBF classed by the same
// bit tests); continuation bytes are not checked, and any code point above
// 0xFF, or equal to zero, comes out as '?'. A zero byte in lead position
// marks end of text and produces no output beat; a zero byte inside a
// sequence counts as a continuation. The block takes one input beat per
// clock while the output is not stalled: a beat is held in the input
// register and then decoded into the result register that drives
// out_valid and latin1_char. The accumulator update is one shift and OR
// into a 32-bit register; back-pressure on the output stalls the decode
// stage, and the input register holds one more beat before in_ready drops.
// ----------------------------------------------------------------------------
module utf8_to_latin1_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] latin1_char
);

    utl1_pkg::beat_t stage_beat;
    logic            stage_take;

    // Hold the incoming beat until the decode stage advances
    utl1_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_byte    (in_byte),
        .stage_beat (stage_beat),
        .stage_take (stage_take)
    );

    // Decode, accumulate and register the Latin-1 result
    utl1_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .stage_beat  (stage_beat),
        .stage_take  (stage_take),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .latin1_char (latin1_char)
    );

endmodule

// ===== hdl/utl1_in_reg.sv =====
// ----------------------------------------------------------------------------
// utl1_in_reg
// Input register: captures one byte beat and holds it until the decode stage
// takes it; refills in the same cycle so a beat enters every unstalled clock.
// ----------------------------------------------------------------------------
module utl1_in_reg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [utl1_pkg::BYTE_W-1:0] in_byte,
    output utl1_pkg::beat_t             stage_beat,
    input  logic                        stage_take
);

    logic                        vld_reg;
    logic                        vld_next;
    logic [utl1_pkg::BYTE_W-1:0] byte_reg;
    logic                        load;

    assign in_ready = !vld_reg || stage_take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (load)
            vld_next = 1'b1;
        else if (stage_take)
            vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    // Payload needs no reset
    always_ff @(posedge clk)
    begin
        if (load)
            byte_reg <= in_byte;
    end

    assign stage_beat.vld  = vld_reg;
    assign stage_beat.data = byte_reg;

endmodule

// ===== hdl/utl1_core.sv =====
// ----------------------------------------------------------------------------
// utl1_core
// Decode stage: sequence state, code point accumulation and the result
// register on the output channel.
// ----------------------------------------------------------------------------
module utl1_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  utl1_pkg::beat_t             stage_beat,
    output logic                        stage_take,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [utl1_pkg::BYTE_W-1:0] latin1_char
);

    logic [utl1_pkg::COUNT_W-1:0] bytes_left_reg;
    logic [utl1_pkg::COUNT_W-1:0] bytes_left_next;
    logic [utl1_pkg::ACCUM_W-1:0] code_accum_reg;
    logic [utl1_pkg::ACCUM_W-1:0] code_accum_next;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [utl1_pkg::BYTE_W-1:0]  char_reg;
    logic [utl1_pkg::BYTE_W-1:0]  char_next;

    logic [utl1_pkg::BYTE_W-1:0]  b;
    logic [utl1_pkg::COUNT_W-1:0] len;
    logic [utl1_pkg::BYTE_W-1:0]  lead_mask;
    logic [utl1_pkg::ACCUM_W-1:0] lead_bits;
    logic [utl1_pkg::ACCUM_W-1:0] cont_bits;
    logic [utl1_pkg::COUNT_W-1:0] left_dec;
    logic                         emit;
    logic                         slot_free;

    assign b        = stage_beat.data;
    assign len      = utl1_pkg::seq_len(b);
    assign lead_mask = utl1_pkg::FULL_MASK >> ({1'b0, len} + 4'd1);
    assign lead_bits = {24'd0, b & lead_mask};
    // byte - 0x80 in 32-bit two's complement
    assign cont_bits = {{(utl1_pkg::ACCUM_W-7){~b[7]}}, b[6:0]};
    assign left_dec  = bytes_left_reg - 3'd1;

    assign slot_free  = !out_vld_reg || out_ready;
    assign stage_take = stage_beat.vld && slot_free;

    always_comb
    begin
        bytes_left_next = bytes_left_reg;
        code_accum_next = code_accum_reg;
        emit            = 1'b0;
        char_next       = char_reg;
        if (stage_take)
        begin
            if (bytes_left_reg == '0)
            begin
                if (len == utl1_pkg::LEN_ONE)
                begin
                    // Pass ASCII through; drop the end-of-text marker
                    emit      = (b != utl1_pkg::END_OF_TEXT);
                    char_next = b;
                end
                else
                begin
                    code_accum_next = lead_bits << utl1_pkg::group_pos(len - 3'd1);
                    bytes_left_next = len - 3'd1;
                end
            end
            else
            begin
                code_accum_next = code_accum_reg |
                                  (cont_bits << utl1_pkg::group_pos(left_dec));
                bytes_left_next = left_dec;
                if (left_dec == '0)
                begin
                    emit = 1'b1;
                    if ((code_accum_next > {24'd0, utl1_pkg::LATIN1_MAX}) ||
                        (code_accum_next == '0))
                        char_next = utl1_pkg::SUBST_CHAR;
                    else
                        char_next = code_accum_next[utl1_pkg::BYTE_W-1:0];
                end
            end
        end
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit)
            out_vld_next = 1'b1;
        else if (out_ready)
            out_vld_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left_reg <= '0;
            code_accum_reg <= '0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            bytes_left_reg <= bytes_left_next;
            code_accum_reg <= code_accum_next;
            out_vld_reg    <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            char_reg <= char_next;
    end

    assign out_valid   = out_vld_reg;
    assign latin1_char = char_reg;

endmodule
